FILE: sv/rwb_pkg.sv
// shared codes and fixed field widths for the retransmit window buffer
`timescale 1ns / 1ps

package rwb_pkg;

  localparam int OP_W   = 2;
  localparam int SEQ_W  = 31;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

endpackage

FILE: sv/rwb_in_if.sv
// request channel: one window operation per word
`timescale 1ns / 1ps

interface rwb_in_if #(
  parameter int HANDLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic [rwb_pkg::OP_W-1:0]    operation;
  logic [rwb_pkg::SEQ_W-1:0]   seq_num;
  logic [HANDLE_BITS-1:0]      buffer_handle;
  logic [rwb_pkg::SEQ_W-1:0]   ack_number;

  modport source (output valid, operation, seq_num, buffer_handle, ack_number, input ready);
  modport sink (input valid, operation, seq_num, buffer_handle, ack_number, output ready);
endinterface

FILE: sv/rwb_out_if.sv
// result channel: outcome and window summary per word
`timescale 1ns / 1ps

interface rwb_out_if #(
  parameter int HANDLE_BITS = 16,
  parameter int CNT_W       = 7
);
  logic                        valid;
  logic                        ready;
  logic [rwb_pkg::STAT_W-1:0]  status;
  logic [HANDLE_BITS-1:0]      found_handle;
  logic [CNT_W-1:0]            removed_count;
  logic [CNT_W-1:0]            window_count;
  logic                        window_full;
  logic                        window_empty;
  logic [HANDLE_BITS-1:0]      oldest_handle;
  logic [HANDLE_BITS-1:0]      newest_handle;

  modport source (
    output valid, status, found_handle, removed_count, window_count, window_full,
           window_empty, oldest_handle, newest_handle,
    input  ready
  );
  modport sink (
    input  valid, status, found_handle, removed_count, window_count, window_full,
           window_empty, oldest_handle, newest_handle,
    output ready
  );
endinterface

FILE: sv/rwb_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module rwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/retransmit_window_buffer.sv
// top level: ring of unacknowledged segments with add, cumulative ack and lookup
// An add goes via S_DONE to the result register. A cumulative ack or a lookup walks
// the held entries from the oldest one through a single ram read port, one entry
// per cycle, until the ack meets an unacked entry or the lookup hits. One word is
// in flight at a time; the next request is taken once the result register is free
// or being drained. The ram needs no clearing after reset: only held entries are
// ever read. The user must write capacity through cfg_wr_en/cfg_wr_data only while
// idle; the block does not check. Zero acts as 1; values above DEPTH act as DEPTH.
`timescale 1ns / 1ps

module retransmit_window_buffer #(
  parameter int DEPTH       = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [$clog2(DEPTH+1)-1:0]   cfg_wr_data,
  rwb_in_if.sink                       req,
  rwb_out_if.source                    rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int ENT_W = rwb_pkg::SEQ_W + HANDLE_BITS;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  logic [1:0]                  state;
  logic [CNT_W-1:0]            capacity;
  logic [IDX_W-1:0]            head;
  logic [IDX_W-1:0]            tail;
  logic [CNT_W-1:0]            count;
  logic [HANDLE_BITS-1:0]      oldest;
  logic [HANDLE_BITS-1:0]      newest;

  logic [rwb_pkg::OP_W-1:0]    op;
  logic [rwb_pkg::SEQ_W-1:0]   key_seq;
  logic [rwb_pkg::SEQ_W-1:0]   key_ack;
  logic [rwb_pkg::STAT_W-1:0]  stat;
  logic [HANDLE_BITS-1:0]      found;
  logic [CNT_W-1:0]            removed;

  logic [IDX_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            rd_left;
  logic                        cmp_valid;

  logic                        accept;
  logic [CNT_W-1:0]            cap_eff;
  logic                        full_now;
  logic                        issue;
  logic                        ram_wr_en;
  logic [ENT_W-1:0]            ram_wr_data;
  logic [ENT_W-1:0]            rd_data;
  logic [rwb_pkg::SEQ_W-1:0]   rd_seq;
  logic [HANDLE_BITS-1:0]      rd_handle;

  assign cap_eff  = (capacity == '0) ? CNT_W'(1) : ((capacity > DEPTH_C) ? DEPTH_C : capacity);
  assign full_now = (count >= cap_eff);

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign ram_wr_en   = accept && (req.operation == rwb_pkg::OP_ADD) && !full_now;
  assign ram_wr_data = {req.seq_num, req.buffer_handle};
  assign issue       = (state == S_SCAN) && (rd_left != '0);

  assign rd_seq    = rd_data[ENT_W-1:HANDLE_BITS];
  assign rd_handle = rd_data[HANDLE_BITS-1:0];

  rwb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail),
    .wr_data (ram_wr_data),
    .rd_en   (issue),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= DEPTH_C;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // sequencer: add finishes at once, ack and lookup stream reads from the head
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
      rd_left   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= req.operation;
            key_seq   <= req.seq_num;
            key_ack   <= req.ack_number;
            found     <= '0;
            removed   <= '0;
            rd_ptr    <= head;
            rd_left   <= count;
            cmp_valid <= 1'b0;
            case (req.operation)
              rwb_pkg::OP_ADD: begin
                if (full_now) begin
                  stat <= rwb_pkg::STAT_DROPPED;
                end else begin
                  stat   <= rwb_pkg::STAT_OK;
                  tail   <= ring_next(tail);
                  count  <= count + CNT_W'(1);
                  newest <= req.buffer_handle;
                  if (count == '0) begin
                    oldest <= req.buffer_handle;
                  end
                end
                state <= S_DONE;
              end
              rwb_pkg::OP_ACK: begin
                stat  <= rwb_pkg::STAT_OK;
                state <= S_SCAN;
              end
              rwb_pkg::OP_LOOKUP: begin
                stat  <= rwb_pkg::STAT_NOTFOUND;
                state <= S_SCAN;
              end
              default: begin
                stat  <= rwb_pkg::STAT_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          if (issue) begin
            rd_ptr  <= ring_next(rd_ptr);
            rd_left <= rd_left - CNT_W'(1);
          end
          if (cmp_valid) begin
            if (op == rwb_pkg::OP_ACK) begin
              if (rd_seq < key_ack) begin
                head    <= ring_next(head);
                count   <= count - CNT_W'(1);
                removed <= removed + CNT_W'(1);
              end else begin
                oldest <= rd_handle;
                state  <= S_DONE;
              end
            end else if (rd_seq == key_seq) begin
              found <= rd_handle;
              stat  <= rwb_pkg::STAT_OK;
              state <= S_DONE;
            end
          end else if (rd_left == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register, loaded once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      rsp.status        <= stat;
      rsp.found_handle  <= found;
      rsp.removed_count <= removed;
      rsp.window_count  <= count;
      rsp.window_full   <= full_now;
      rsp.window_empty  <= (count == '0);
      rsp.oldest_handle <= (count == '0) ? '0 : oldest;
      rsp.newest_handle <= (count == '0) ? '0 : newest;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("window count above depth");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !rsp.valid)
    else $error("result loaded while previous word still pending");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while a word is in flight");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (cmp_valid && state == S_SCAN && op == rwb_pkg::OP_ACK && rd_seq < key_ack)
      |=> (count == $past(count) - CNT_W'(1)))
    else $error("ack release did not shrink the window");
`endif

endmodule

FILE: sim/tb_retransmit_window_buffer.sv
// testbench for the retransmit window buffer: directed and random traffic against a predictor
`timescale 1ns / 1ps

module tb_retransmit_window_buffer;

  localparam int DEPTH       = 64;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_W       = 7;
  localparam int OP_W        = rwb_pkg::OP_W;
  localparam int SEQ_W       = rwb_pkg::SEQ_W;
  localparam int STAT_W      = rwb_pkg::STAT_W;

  localparam logic [OP_W-1:0]  OP_NONE = 2'd3;
  localparam logic [SEQ_W-1:0] SEQ_TOP = '1;

  typedef struct {
    logic [OP_W-1:0]        operation;
    logic [SEQ_W-1:0]       seq_num;
    logic [HANDLE_BITS-1:0] buffer_handle;
    logic [SEQ_W-1:0]       ack_number;
  } window_req_t;

  typedef struct {
    logic [STAT_W-1:0]      status;
    logic [HANDLE_BITS-1:0] found_handle;
    logic [CNT_W-1:0]       removed_count;
    logic [CNT_W-1:0]       window_count;
    logic                   window_full;
    logic                   window_empty;
    logic [HANDLE_BITS-1:0] oldest_handle;
    logic [HANDLE_BITS-1:0] newest_handle;
  } window_rsp_t;

  // mirror of the segment ring and the summary words it should produce
  class window_tracker;
    logic [SEQ_W-1:0]       seq_ring [DEPTH];
    logic [HANDLE_BITS-1:0] handle_ring [DEPTH];
    int unsigned            head = 0;
    int unsigned            tail = 0;
    int unsigned            held = 0;
    logic [CNT_W-1:0]       capacity_reg = 7'd64;
    window_rsp_t            expected_summaries [$];

    function int unsigned capacity_limit();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > DEPTH) return DEPTH;
      return capacity_reg;
    endfunction

    function logic [SEQ_W-1:0] seq_at(int unsigned k);
      return seq_ring[(head + k) % DEPTH];
    endfunction

    function void apply_request(window_req_t r);
      window_rsp_t e;
      int unsigned cap;
      int unsigned idx;
      int unsigned n;
      cap = capacity_limit();
      e.status        = rwb_pkg::STAT_OK;
      e.found_handle  = '0;
      e.removed_count = '0;
      case (r.operation)
        rwb_pkg::OP_ADD: begin
          if (held >= cap) begin
            e.status = rwb_pkg::STAT_DROPPED;
          end else begin
            seq_ring[tail]    = r.seq_num;
            handle_ring[tail] = r.buffer_handle;
            tail = (tail + 1) % DEPTH;
            held++;
          end
        end
        rwb_pkg::OP_ACK: begin
          while (held > 0 && seq_ring[head] < r.ack_number) begin
            head = (head + 1) % DEPTH;
            held--;
            e.removed_count = e.removed_count + 1'b1;
          end
        end
        rwb_pkg::OP_LOOKUP: begin
          // oldest match wins
          e.status = rwb_pkg::STAT_NOTFOUND;
          for (n = 0; n < held; n++) begin
            idx = (head + n) % DEPTH;
            if (seq_ring[idx] == r.seq_num) begin
              e.found_handle = handle_ring[idx];
              e.status       = rwb_pkg::STAT_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      e.window_count  = held[CNT_W-1:0];
      e.window_full   = (held >= cap);
      e.window_empty  = (held == 0);
      e.oldest_handle = (held == 0) ? '0 : handle_ring[head];
      e.newest_handle = (held == 0) ? '0 : handle_ring[(tail + DEPTH - 1) % DEPTH];
      expected_summaries.push_back(e);
    endfunction

    // empty string when the word matches the oldest expected summary
    function string check_summary(window_rsp_t got);
      window_rsp_t want;
      string diffs;
      diffs = "";
      if (expected_summaries.size() == 0) return "result word with no request waiting";
      want = expected_summaries.pop_front();
      if (got.status !== want.status)
        diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
      if (got.found_handle !== want.found_handle)
        diffs = {diffs, $sformatf(" found %h/%h", got.found_handle, want.found_handle)};
      if (got.removed_count !== want.removed_count)
        diffs = {diffs, $sformatf(" removed %0d/%0d", got.removed_count, want.removed_count)};
      if (got.window_count !== want.window_count)
        diffs = {diffs, $sformatf(" count %0d/%0d", got.window_count, want.window_count)};
      if (got.window_full !== want.window_full)
        diffs = {diffs, $sformatf(" full %b/%b", got.window_full, want.window_full)};
      if (got.window_empty !== want.window_empty)
        diffs = {diffs, $sformatf(" empty %b/%b", got.window_empty, want.window_empty)};
      if (got.oldest_handle !== want.oldest_handle)
        diffs = {diffs, $sformatf(" oldest %h/%h", got.oldest_handle, want.oldest_handle)};
      if (got.newest_handle !== want.newest_handle)
        diffs = {diffs, $sformatf(" newest %h/%h", got.newest_handle, want.newest_handle)};
      return diffs;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  rwb_in_if  #(.HANDLE_BITS(HANDLE_BITS))                req_if ();
  rwb_out_if #(.HANDLE_BITS(HANDLE_BITS), .CNT_W(CNT_W)) rsp_if ();

  retransmit_window_buffer #(
    .DEPTH      (DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  window_tracker    tracker = new();
  int unsigned      mismatch_count = 0;
  int unsigned      gap_rate = 0;
  int unsigned      stall_rate = 0;
  int unsigned      stall_left = 0;
  logic [SEQ_W-1:0] next_seq = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t ns:%s", $time, what);
  endtask

  // receiver drops ready in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      rsp_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (stall_rate != 0 && $urandom_range(0, 31) < stall_rate) begin
      stall_left <= $urandom_range(0, 15);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    window_rsp_t got;
    string       msg;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.status        = rsp_if.status;
      got.found_handle  = rsp_if.found_handle;
      got.removed_count = rsp_if.removed_count;
      got.window_count  = rsp_if.window_count;
      got.window_full   = rsp_if.window_full;
      got.window_empty  = rsp_if.window_empty;
      got.oldest_handle = rsp_if.oldest_handle;
      got.newest_handle = rsp_if.newest_handle;
      msg = tracker.check_summary(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  function automatic window_req_t req_of(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                                         input logic [HANDLE_BITS-1:0] handle,
                                         input logic [SEQ_W-1:0] ack);
    window_req_t r;
    r.operation     = op;
    r.seq_num       = seq;
    r.buffer_handle = handle;
    r.ack_number    = ack;
    return r;
  endfunction

  // mostly ordered segment traffic; noisy words use any field values
  function automatic window_req_t make_request(input bit noisy, input int unsigned add_weight);
    window_req_t r;
    int unsigned pick;
    r.operation     = OP_NONE;
    r.seq_num       = SEQ_W'($urandom);
    r.buffer_handle = HANDLE_BITS'($urandom);
    r.ack_number    = SEQ_W'($urandom);
    pick = $urandom_range(0, 99);
    if (noisy) begin
      r.operation = OP_W'($urandom_range(0, 3));
      // a top sequence number could never be acked and would jam the head
      if (r.operation == rwb_pkg::OP_ADD && r.seq_num == SEQ_TOP) r.seq_num = SEQ_TOP - 1'b1;
    end else if (pick < add_weight) begin
      r.operation = rwb_pkg::OP_ADD;
      if ($urandom_range(0, 49) == 0) next_seq = SEQ_W'($urandom_range(0, 32'h7FFF_FFF0));
      else if ($urandom_range(0, 9) != 0) next_seq = next_seq + SEQ_W'($urandom_range(1, 1000));
      if (next_seq == SEQ_TOP) next_seq = '0;
      r.seq_num = next_seq;
    end else if (pick < add_weight + (100 - add_weight) / 2) begin
      r.operation = rwb_pkg::OP_ACK;
      if (tracker.held == 0 || $urandom_range(0, 7) == 0)
        r.ack_number = $urandom_range(0, 1) ? SEQ_TOP : '0;
      else
        r.ack_number = tracker.seq_at($urandom_range(0, tracker.held - 1))
                       + SEQ_W'($urandom_range(0, 1));
    end else if (pick < 98) begin
      r.operation = rwb_pkg::OP_LOOKUP;
      if (tracker.held != 0 && $urandom_range(0, 3) != 0)
        r.seq_num = tracker.seq_at($urandom_range(0, tracker.held - 1));
      else if ($urandom_range(0, 1) != 0)
        r.seq_num = next_seq + 1'b1;
    end
    return r;
  endfunction

  task automatic send_request(input window_req_t r);
    req_if.valid         <= 1'b1;
    req_if.operation     <= r.operation;
    req_if.seq_num       <= r.seq_num;
    req_if.buffer_handle <= r.buffer_handle;
    req_if.ack_number    <= r.ack_number;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    tracker.apply_request(r);
  endtask

  task automatic idle_sender();
    req_if.valid <= 1'b0;
    repeat ($urandom_range(1, 16)) @(posedge clk);
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (tracker.expected_summaries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] value);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.capacity_reg = value;
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned add_weight;
    logic [CNT_W-1:0] cap;
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    req_if.valid         <= 1'b0;
    req_if.operation     <= rwb_pkg::OP_ADD;
    req_if.seq_num       <= '0;
    req_if.buffer_handle <= '0;
    req_if.ack_number    <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty window, extremes, duplicates, ack stopping at an unacked head
    send_request(req_of(rwb_pkg::OP_ACK, '0, '0, '0));
    send_request(req_of(rwb_pkg::OP_LOOKUP, '0, '0, '0));
    send_request(req_of(OP_NONE, SEQ_TOP, 16'hFFFF, SEQ_TOP));
    send_request(req_of(rwb_pkg::OP_ADD, '0, 16'h0000, '0));
    send_request(req_of(rwb_pkg::OP_ADD, SEQ_TOP - 1'b1, 16'hFFFF, '0));
    send_request(req_of(rwb_pkg::OP_ADD, '0, 16'h1234, SEQ_TOP));
    send_request(req_of(rwb_pkg::OP_LOOKUP, '0, '0, '0));
    send_request(req_of(rwb_pkg::OP_LOOKUP, SEQ_TOP - 1'b1, '0, '0));
    send_request(req_of(rwb_pkg::OP_LOOKUP, SEQ_TOP, '0, '0));
    send_request(req_of(rwb_pkg::OP_ACK, '0, '0, '0));
    send_request(req_of(OP_NONE, '0, '0, '0));
    send_request(req_of(rwb_pkg::OP_ACK, '0, '0, 31'd1));
    send_request(req_of(rwb_pkg::OP_LOOKUP, '0, '0, '0));
    send_request(req_of(rwb_pkg::OP_ACK, '0, '0, SEQ_TOP));

    // small capacity, then capacity lowered under the held count
    set_capacity(7'd2);
    send_request(req_of(rwb_pkg::OP_ADD, 31'd10, 16'hAAAA, '0));
    send_request(req_of(rwb_pkg::OP_ADD, 31'd20, 16'h5555, '0));
    send_request(req_of(rwb_pkg::OP_ADD, 31'd30, 16'h0F0F, '0));
    set_capacity(7'd1);
    send_request(req_of(rwb_pkg::OP_ADD, 31'd40, 16'hF0F0, '0));
    send_request(req_of(rwb_pkg::OP_LOOKUP, 31'd20, '0, '0));
    send_request(req_of(rwb_pkg::OP_ACK, '0, '0, 31'd11));
    send_request(req_of(rwb_pkg::OP_ADD, 31'd50, 16'h00FF, '0));
    send_request(req_of(rwb_pkg::OP_ACK, '0, '0, SEQ_TOP));
    next_seq = 31'd100;

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cap = 7'd1;
        1: cap = 7'd0;
        2: cap = 7'd127;
        3: cap = 7'd64;
        4: cap = 7'd2;
        8: cap = 7'd65;
        9: cap = 7'd64;
        default: cap = CNT_W'($urandom_range(3, 63));
      endcase
      set_capacity(cap);
      add_weight = (ph == 3 || ph == 9) ? 70 : $urandom_range(40, 65);
      for (n = 0; n < 190; n++) begin
        if (n % 50 == 0) begin
          // last phase runs with no idling at all
          gap_rate   = (ph == 9) ? 0 : $urandom_range(0, 6);
          stall_rate = (ph == 9) ? 0 : $urandom_range(0, 6);
        end
        if (gap_rate != 0 && $urandom_range(0, 31) < gap_rate) idle_sender();
        if (ph != 9 && $urandom_range(0, 149) == 0) wait_for_results();
        send_request(make_request($urandom_range(0, 99) < 12, add_weight));
      end
    end

    wait_for_results();
    repeat (72) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[retransmit_window_buffer] OK");
    end else begin
      $display("[retransmit_window_buffer] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[retransmit_window_buffer] ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/rwb_pkg.sv
sv/rwb_in_if.sv
sv/rwb_out_if.sv
sv/rwb_ram.sv
sv/retransmit_window_buffer.sv
sim/tb_retransmit_window_buffer.sv
